// ===== rtl/ldt_pkg.sv =====
// ldt_pkg: shared types, codes and helpers of the lowest-free descriptor table
// used by the channel interfaces and every module of the block
`default_nettype none

package ldt_pkg;

    localparam int DEF_TABLE_SIZE = 32;
    localparam int MAX_REPORTED   = 32;
    localparam int CFG_IDX_W      = 2;

    localparam logic [31:0] NULL_HANDLE = 32'hFFFF_FFFF;
    localparam logic [5:0]  COUNT_MAX   = 6'd63;

    localparam logic [3:0] OP_INIT   = 4'd0;
    localparam logic [3:0] OP_ALLOC  = 4'd1;
    localparam logic [3:0] OP_FREE   = 4'd2;
    localparam logic [3:0] OP_DUP    = 4'd3;
    localparam logic [3:0] OP_GETCX  = 4'd4;
    localparam logic [3:0] OP_SETCX  = 4'd5;
    localparam logic [3:0] OP_LOOKUP = 4'd6;
    localparam logic [3:0] OP_COUNT  = 4'd7;
    localparam logic [3:0] OP_SWEEP  = 4'd8;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_BAD_FD = 2'd1;
    localparam logic [1:0] STS_FULL   = 2'd2;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_STDIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STDOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STDERR = 2'd2;

    typedef struct packed {
        logic [3:0]  operation;
        logic [9:0]  slot_number;
        logic [9:0]  target_slot;
        logic [31:0] handle_in;
        logic [1:0]  access_mode_in;
        logic        cloexec_request;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  slot_out;
        logic [31:0] handle_out;
        logic [1:0]  access_mode_out;
        logic        cloexec_out;
        logic [5:0]  used_count;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [31:0] handle;
        logic [1:0]  mode;
        logic        cloexec;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_entry data;
    } t_mem_wr;

    typedef struct packed {
        logic [31:0] stdin_handle;
        logic [31:0] stdout_handle;
        logic [31:0] stderr_handle;
    } t_cfg;

    localparam t_entry ENTRY_FREE = '{handle: NULL_HANDLE, mode: MODE_READ, cloexec: 1'b0};

    function automatic t_rsp rsp_final(input logic [1:0] sts);
        t_rsp r;
        r = '{status: sts, slot_out: 10'd0, handle_out: NULL_HANDLE,
              access_mode_out: 2'd0, cloexec_out: 1'b0, used_count: 6'd0, last: 1'b1};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ldt_if.sv =====
// ldt_if: valid/ready channel interfaces for requests, results and register writes
// depends on ldt_pkg for the payload types
`default_nettype none

interface ldt_req_if import ldt_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ldt_rsp_if import ldt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ldt_cfg_if import ldt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lowest_free_descriptor_table.sv =====
// lowest_free_descriptor_table: top level of the lowest-free descriptor table
// depends on ldt_pkg, ldt_if, ldt_cfg_regs, ldt_slot_mem and ldt_ctrl
//
// Requests arrive on i_req (valid/ready), results leave on o_rsp (valid/ready),
// and the three standard handles are written on i_cfg, which is always ready.
// One request is handled at a time; i_req.ready is high only while idle.
// Free, dup, get/set close-on-exec and lookup pass through a slot read, an
// update and a result load, in that order. Alloc, count and the close-on-exec
// sweep read the slot store one entry per cycle, though a stalled receiver can
// hold the sweep; alloc stops at the first free slot. Init rewrites every slot,
// one per cycle. A null alloc or an unknown operation goes straight to the
// result load. The scan rate is set by the single read port of the slot store.
// After reset the block clears the slot store, one entry per cycle, before it
// takes the first request; register writes are taken throughout.
// Results sit in one output register; a stalled receiver holds the sweep at the
// slot being reported and holds the final result until it is taken.
`default_nettype none

module lowest_free_descriptor_table import ldt_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ldt_req_if.sink    i_req,
    ldt_rsp_if.source  o_rsp,
    ldt_cfg_if.sink    i_cfg
);

    localparam int SW = $clog2(TABLE_SIZE);

    t_cfg          cfg;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] wr_addr;
    t_entry        rd_data;
    t_mem_wr       wr;

    ldt_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    ldt_slot_mem #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    ldt_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .i_cfg     (cfg),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_addr (wr_addr),
        .o_wr      (wr)
    );

endmodule

`default_nettype wire

// ===== rtl/ldt_cfg_regs.sv =====
// ldt_cfg_regs: standard stream handle registers, written on i_cfg and copied into the slots by init
// depends on ldt_pkg and ldt_cfg_if
`default_nettype none

module ldt_cfg_regs import ldt_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ldt_cfg_if.sink    i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{stdin_handle: NULL_HANDLE, stdout_handle: NULL_HANDLE,
                       stderr_handle: NULL_HANDLE};
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STDIN:  r_cfg.stdin_handle  <= i_cfg.data;
                CFG_STDOUT: r_cfg.stdout_handle <= i_cfg.data;
                CFG_STDERR: r_cfg.stderr_handle <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ldt_slot_mem.sv =====
// ldt_slot_mem: slot store, one write and one registered read per cycle
// depends on ldt_pkg for the entry layout
`default_nettype none

module ldt_slot_mem import ldt_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  wire                           i_clk,
    input  wire [$clog2(TABLE_SIZE)-1:0]  i_rd_addr,
    output t_entry                        o_rd_data,
    input  wire [$clog2(TABLE_SIZE)-1:0]  i_wr_addr,
    input  t_mem_wr                       i_wr
);

    t_entry r_mem [TABLE_SIZE];
    t_entry r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/ldt_ctrl.sv =====
// ldt_ctrl: request sequencer, slot scans, read-modify-write and result register
// depends on ldt_pkg and ldt_if; drives the slot store through its ports
`default_nettype none

module ldt_ctrl import ldt_pkg::*; #(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    ldt_req_if.sink                       i_req,
    ldt_rsp_if.source                     o_rsp,
    input  t_cfg                          i_cfg,
    output logic [$clog2(TABLE_SIZE)-1:0] o_rd_addr,
    input  t_entry                        i_rd_data,
    output logic [$clog2(TABLE_SIZE)-1:0] o_wr_addr,
    output t_mem_wr                       o_wr
);

    localparam int SW = $clog2(TABLE_SIZE);
    localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SIZE - 1);
    localparam logic [5:0] REP_MAX = 6'(MAX_REPORTED);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_PT   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]    r_state, n_state;
    t_req          r_req, n_req;
    logic          r_init, n_init;
    logic [SW-1:0] r_idx, n_idx;
    logic [SW-1:0] r_qaddr, n_qaddr;
    logic [5:0]    r_cnt, n_cnt;
    logic [5:0]    r_nrep, n_nrep;
    t_rsp          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;

    logic    out_free;
    logic    emit;
    t_rsp    emit_data;
    logic    scan_hold;
    logic    q_used;
    logic    s_ok;
    logic    s_used;
    logic    t_ok;
    logic    is_last;
    logic [SW-1:0] next_addr;
    t_entry  wdata;

    assign out_free      = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;
    assign i_req.ready   = (r_state == S_IDLE);

    assign q_used    = (i_rd_data.handle != NULL_HANDLE);
    assign s_ok      = (11'(r_req.slot_number) < 11'(TABLE_SIZE));
    assign s_used    = s_ok && q_used;
    assign t_ok      = (11'(r_req.target_slot) < 11'(TABLE_SIZE));
    assign is_last   = (r_qaddr == LAST_IDX);
    assign next_addr = is_last ? '0 : r_qaddr + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_init    = r_init;
        n_idx     = r_idx;
        n_qaddr   = r_qaddr;
        n_cnt     = r_cnt;
        n_nrep    = r_nrep;
        n_res     = r_res;
        emit      = 1'b0;
        emit_data = rsp_final(STS_OK);
        scan_hold = 1'b0;
        o_rd_addr = r_qaddr;
        o_wr_addr = r_qaddr;
        wdata     = ENTRY_FREE;
        o_wr.en   = 1'b0;

        case (r_state)
            S_CLR: begin
                o_wr.en   = 1'b1;
                o_wr_addr = r_idx;
                if (r_init) begin
                    if (r_idx == SW'(0)) begin
                        wdata.handle = i_cfg.stdin_handle;
                    end else if (r_idx == SW'(1)) begin
                        wdata.handle = i_cfg.stdout_handle;
                        wdata.mode   = MODE_WRITE;
                    end else if (r_idx == SW'(2)) begin
                        wdata.handle = i_cfg.stderr_handle;
                        wdata.mode   = MODE_WRITE;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    if (r_init) begin
                        n_res   = rsp_final(STS_OK);
                        n_state = S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                    n_init = 1'b0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.payload.operation inside {OP_ALLOC, OP_COUNT, OP_SWEEP}) begin
                    o_rd_addr = '0;
                end else begin
                    o_rd_addr = i_req.payload.slot_number[SW-1:0];
                end
                if (i_req.valid) begin
                    n_req   = i_req.payload;
                    n_qaddr = o_rd_addr;
                    n_cnt   = '0;
                    n_nrep  = '0;
                    case (i_req.payload.operation)
                        OP_INIT: begin
                            n_init  = 1'b1;
                            n_idx   = '0;
                            n_state = S_CLR;
                        end
                        OP_ALLOC: begin
                            if (i_req.payload.handle_in == NULL_HANDLE) begin
                                n_res   = rsp_final(STS_BAD_FD);
                                n_state = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_COUNT, OP_SWEEP: n_state = S_SCAN;
                        OP_FREE, OP_DUP, OP_GETCX, OP_SETCX, OP_LOOKUP: n_state = S_PT;
                        default: begin
                            n_res   = rsp_final(STS_BAD_FD);
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_PT: begin
                n_res   = rsp_final(STS_OK);
                n_state = S_RESP;
                case (r_req.operation)
                    OP_FREE: begin
                        if (s_used) begin
                            o_wr.en = 1'b1;
                        end else begin
                            n_res.status = STS_BAD_FD;
                        end
                    end
                    OP_DUP: begin
                        if (s_used && t_ok) begin
                            o_wr.en       = 1'b1;
                            o_wr_addr     = r_req.target_slot[SW-1:0];
                            wdata.handle  = i_rd_data.handle;
                            wdata.mode    = i_rd_data.mode;
                            n_res.slot_out = r_req.target_slot;
                        end else begin
                            n_res.status = STS_BAD_FD;
                        end
                    end
                    OP_GETCX: begin
                        n_res.cloexec_out = s_ok && i_rd_data.cloexec;
                    end
                    OP_SETCX: begin
                        if (s_used) begin
                            o_wr.en       = 1'b1;
                            wdata         = i_rd_data;
                            wdata.cloexec = r_req.cloexec_request;
                        end else begin
                            n_res.status = STS_BAD_FD;
                        end
                    end
                    OP_LOOKUP: begin
                        if (s_ok) begin
                            n_res.handle_out      = i_rd_data.handle;
                            n_res.access_mode_out = i_rd_data.mode;
                            n_res.cloexec_out     = i_rd_data.cloexec;
                        end
                    end
                    default: begin
                        n_res.status = STS_BAD_FD;
                    end
                endcase
            end
            S_SCAN: begin
                case (r_req.operation)
                    OP_ALLOC: begin
                        if (!q_used) begin
                            o_wr.en        = 1'b1;
                            wdata.handle   = r_req.handle_in;
                            wdata.mode     = r_req.access_mode_in;
                            wdata.cloexec  = r_req.cloexec_request;
                            n_res          = rsp_final(STS_OK);
                            n_res.slot_out = 10'(r_qaddr);
                            n_state        = S_RESP;
                        end else if (is_last) begin
                            n_res   = rsp_final(STS_FULL);
                            n_state = S_RESP;
                        end
                    end
                    OP_COUNT: begin
                        if (q_used && r_cnt != COUNT_MAX) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        if (is_last) begin
                            n_res            = rsp_final(STS_OK);
                            n_res.used_count = n_cnt;
                            n_state          = S_RESP;
                        end
                    end
                    default: begin
                        if (q_used && i_rd_data.cloexec) begin
                            if (r_nrep < REP_MAX) begin
                                if (out_free) begin
                                    emit                      = 1'b1;
                                    emit_data.slot_out        = 10'(r_qaddr);
                                    emit_data.handle_out      = i_rd_data.handle;
                                    emit_data.access_mode_out = i_rd_data.mode;
                                    emit_data.cloexec_out     = 1'b1;
                                    emit_data.last            = 1'b0;
                                    o_wr.en                   = 1'b1;
                                    n_nrep                    = r_nrep + 1'b1;
                                end else begin
                                    scan_hold = 1'b1;
                                end
                            end else begin
                                o_wr.en = 1'b1;
                            end
                        end
                        if (!scan_hold && is_last) begin
                            n_res   = rsp_final(STS_OK);
                            n_state = S_RESP;
                        end
                    end
                endcase
                o_rd_addr = scan_hold ? r_qaddr : next_addr;
                n_qaddr   = o_rd_addr;
            end
            S_RESP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_data = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_wr.data   = wdata;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init      <= n_init;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_qaddr <= n_qaddr;
        r_cnt   <= n_cnt;
        r_nrep  <= n_nrep;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    a_wr_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_state == S_CLR || r_state == S_PT || r_state == S_SCAN))
        else $error("slot write outside clear, point or scan state");

    a_hold_no_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_hold |-> (!o_wr.en && !emit && o_rd_addr == r_qaddr))
        else $error("stalled sweep step changed the table");

    a_partial_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !emit_data.last) |-> (r_state == S_SCAN && r_req.operation == OP_SWEEP))
        else $error("non-final result outside a sweep");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result register overwritten while full");

    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (r_state == S_CLR && !r_init))
        else $error("reset did not start the clearing pass");

endmodule

`default_nettype wire
